FILE: design/hpb_pkg.sv
package hpb_pkg;

    localparam int PIX_W      = 16;
    localparam int RAMP_W     = 8;
    localparam int CFG_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_GUNS   = 3;
    localparam int GUN_MAX_W  = 8;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    localparam int GUN_RED    = 0;
    localparam int GUN_GREEN  = 1;
    localparam int GUN_BLUE   = 2;

    typedef struct packed {
        logic [CFG_W-1:0] bits;
        logic [CFG_W-1:0] shift;
    } gun_cfg_t;

    typedef gun_cfg_t [NUM_GUNS-1:0] gun_cfg_arr_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_BITS    = 3'd0,
        CFG_RED_SHIFT   = 3'd1,
        CFG_GREEN_BITS  = 3'd2,
        CFG_GREEN_SHIFT = 3'd3,
        CFG_BLUE_BITS   = 3'd4,
        CFG_BLUE_SHIFT  = 3'd5
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] RED_BITS_RST    = 4'd5;
    localparam logic [CFG_W-1:0] RED_SHIFT_RST   = 4'd11;
    localparam logic [CFG_W-1:0] GREEN_BITS_RST  = 4'd6;
    localparam logic [CFG_W-1:0] GREEN_SHIFT_RST = 4'd5;
    localparam logic [CFG_W-1:0] BLUE_BITS_RST   = 4'd5;
    localparam logic [CFG_W-1:0] BLUE_SHIFT_RST  = 4'd0;

endpackage

FILE: design/hpb_cfg_regs.sv
module hpb_cfg_regs
    import hpb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output gun_cfg_arr_t         gun_cfg
);

    gun_cfg_arr_t cfg_reg;
    gun_cfg_arr_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_RED_BITS:    cfg_next[GUN_RED].bits    = cfg_wdata;
                CFG_RED_SHIFT:   cfg_next[GUN_RED].shift   = cfg_wdata;
                CFG_GREEN_BITS:  cfg_next[GUN_GREEN].bits  = cfg_wdata;
                CFG_GREEN_SHIFT: cfg_next[GUN_GREEN].shift = cfg_wdata;
                CFG_BLUE_BITS:   cfg_next[GUN_BLUE].bits   = cfg_wdata;
                CFG_BLUE_SHIFT:  cfg_next[GUN_BLUE].shift  = cfg_wdata;
                default:         cfg_next = cfg_reg; // drop writes past the last register
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[GUN_RED].bits    <= RED_BITS_RST;
            cfg_reg[GUN_RED].shift   <= RED_SHIFT_RST;
            cfg_reg[GUN_GREEN].bits  <= GREEN_BITS_RST;
            cfg_reg[GUN_GREEN].shift <= GREEN_SHIFT_RST;
            cfg_reg[GUN_BLUE].bits   <= BLUE_BITS_RST;
            cfg_reg[GUN_BLUE].shift  <= BLUE_SHIFT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign gun_cfg = cfg_reg;

endmodule

FILE: design/hpb_gun.sv
module hpb_gun
    import hpb_pkg::*;
(
    input  logic [PIX_W-1:0]  pixel,
    input  logic [RAMP_W-1:0] ramp,
    input  gun_cfg_t          cfg,
    output logic [PIX_W-1:0]  gun_out
);

    logic [CFG_W-1:0]     nbits;
    logic [CFG_W-1:0]     pad;
    logic [PIX_W-1:0]     shifted;
    logic [GUN_MAX_W:0]   mask_wide;
    logic [GUN_MAX_W-1:0] field;
    logic [GUN_MAX_W-1:0] g8;
    logic [2*GUN_MAX_W-1:0] prod;
    logic [GUN_MAX_W:0]   sum;
    logic [GUN_MAX_W-1:0] sat;
    logic [GUN_MAX_W-1:0] packed_gun;

    always_comb begin
        // widths above eight act as eight
        nbits     = (cfg.bits > CFG_W'(GUN_MAX_W)) ? CFG_W'(GUN_MAX_W) : cfg.bits;
        pad       = CFG_W'(GUN_MAX_W) - nbits;
        shifted   = pixel >> cfg.shift;
        mask_wide = ((GUN_MAX_W+1)'(1) << nbits) - (GUN_MAX_W+1)'(1);
        field     = shifted[GUN_MAX_W-1:0] & mask_wide[GUN_MAX_W-1:0];
        // left-align, zero-fill below
        g8        = field << pad;
        prod      = g8 * ramp;
        sum       = {1'b0, g8} + {1'b0, prod[2*GUN_MAX_W-1:GUN_MAX_W]};
        sat       = sum[GUN_MAX_W] ? {GUN_MAX_W{1'b1}} : sum[GUN_MAX_W-1:0];
        packed_gun = sat >> pad;
        gun_out   = {{(PIX_W-GUN_MAX_W){1'b0}}, packed_gun} << cfg.shift;
    end

endmodule

FILE: design/hicolor_pixel_brighten_unit.sv
// Saturating brighten of packed hicolor pixels, one pixel per clock while the output is not stalled.
// Input stream (s_*): a transfer carries one pixel and its ramp byte.
// Output stream (m_*): one brightened pixel per input transfer, in order.
// A ramp of zero returns the pixel untouched; otherwise each colour gun is
// unpacked by its configured width and position, gains (gun*ramp)>>8 with
// saturation at full scale and is packed back in place.
// Pipeline: the input register, then the per-gun multiply and saturate into
// the result register. Throughput is one pixel per cycle while m_tready stays
// high, as each stage refills on every clock. When the receiver stalls, the
// result register holds and the input register still takes one more pixel;
// s_tready drops only when both are full. Gun widths and positions are written
// through cfg_we/cfg_index/cfg_wdata; the user must write them only while the
// stream is idle, which the block itself does not enforce. Reset (aresetn low,
// synchronous) empties both stages and loads the 5-6-5 layout: red at bit 11,
// green at 5, blue at 0.
module hicolor_pixel_brighten_unit
    import hpb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [15:0] pixel_in, [23:16] ramp
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // [15:0] pixel_out
);

    gun_cfg_arr_t gun_cfg;

    logic              in_valid_reg, in_valid_next;
    logic [PIX_W-1:0]  in_pixel_reg;
    logic [RAMP_W-1:0] in_ramp_reg;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  out_pixel_reg;
    logic              advance;
    logic [PIX_W-1:0]  gun_out [NUM_GUNS];
    logic [PIX_W-1:0]  result;

    hpb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .gun_cfg   (gun_cfg)
    );

    for (genvar g = 0; g < NUM_GUNS; g++) begin : g_gun
        hpb_gun u_gun (
            .pixel   (in_pixel_reg),
            .ramp    (in_ramp_reg),
            .cfg     (gun_cfg[g]),
            .gun_out (gun_out[g])
        );
    end

    always_comb begin
        result = '0;
        for (int g = 0; g < NUM_GUNS; g++) begin
            result = result | gun_out[g];
        end
        if (in_ramp_reg == '0) begin
            result = in_pixel_reg;
        end
    end

    // result stage moves when empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance || !in_valid_reg;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pixel_reg <= s_tdata[PIX_W-1:0];
            in_ramp_reg  <= s_tdata[PIX_W +: RAMP_W];
        end
        if (advance && in_valid_reg) begin
            out_pixel_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;

endmodule

FILE: design/hpb_checker.sv
module hpb_checker
    import hpb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_wdata,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds its value until the transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // with the result stage empty the input is never back-pressured
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

    // an idle input, followed by the output empty and the input still idle,
    // leaves nothing to present
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tvalid && s_tready) ##1 (!m_tvalid && !(s_tvalid && s_tready))
        |=> !m_tvalid)
        else $error("result appeared without an input transfer");

endmodule

bind hicolor_pixel_brighten_unit hpb_checker u_hpb_checker (.*);

FILE: tb/tb_hicolor_pixel_brighten_unit.sv
module tb_hicolor_pixel_brighten_unit;
    import hpb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT     = 1000;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int NUM_PHASES      = 8;
    localparam int IDLE_PCT        = 19;

    class brighten_scoreboard;
        logic [CFG_W-1:0] gun_bits [NUM_GUNS];
        logic [CFG_W-1:0] gun_shift [NUM_GUNS];
        logic [PIX_W-1:0] expected_pixels [$];
        int n_checked;
        int n_errors;

        function new();
            gun_bits[GUN_RED]    = RED_BITS_RST;
            gun_shift[GUN_RED]   = RED_SHIFT_RST;
            gun_bits[GUN_GREEN]  = GREEN_BITS_RST;
            gun_shift[GUN_GREEN] = GREEN_SHIFT_RST;
            gun_bits[GUN_BLUE]   = BLUE_BITS_RST;
            gun_shift[GUN_BLUE]  = BLUE_SHIFT_RST;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        // Indexes past the blue shift register are dropped, as in the block.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_RED_BITS:    gun_bits[GUN_RED]    = val;
                CFG_RED_SHIFT:   gun_shift[GUN_RED]   = val;
                CFG_GREEN_BITS:  gun_bits[GUN_GREEN]  = val;
                CFG_GREEN_SHIFT: gun_shift[GUN_GREEN] = val;
                CFG_BLUE_BITS:   gun_bits[GUN_BLUE]   = val;
                CFG_BLUE_SHIFT:  gun_shift[GUN_BLUE]  = val;
                default: ;
            endcase
        endfunction

        function logic [PIX_W-1:0] brighten_pixel(logic [PIX_W-1:0] pix,
                                                  logic [RAMP_W-1:0] ramp);
            int unsigned width;
            int unsigned pos;
            int unsigned lane;
            int unsigned boosted;
            int unsigned packed_word;
            if (ramp == 0)
                return pix;
            packed_word = 0;
            for (int g = 0; g < NUM_GUNS; g++) begin
                width = (gun_bits[g] > GUN_MAX_W) ? GUN_MAX_W : gun_bits[g];
                pos   = gun_shift[g];
                // left-align the gun to 8 bits, zero-filling below
                lane  = ((int'(pix) >> pos) & ((32'd1 << width) - 1)) << (GUN_MAX_W - width);
                boosted = lane + ((lane * ramp) >> 8);
                if (boosted > 255)
                    boosted = 255;
                packed_word |= (boosted >> (GUN_MAX_W - width)) << pos;
            end
            return packed_word[PIX_W-1:0];
        endfunction

        function void note_input(logic [PIX_W-1:0] pix, logic [RAMP_W-1:0] ramp);
            expected_pixels.push_back(brighten_pixel(pix, ramp));
        endfunction

        function void check_result(logic [PIX_W-1:0] actual);
            logic [PIX_W-1:0] want;
            if (expected_pixels.size() == 0) begin
                $display("%0t: pixel %h arrived with nothing expected", $time, actual);
                n_errors++;
                return;
            end
            want = expected_pixels.pop_front();
            n_checked++;
            if (actual !== want) begin
                $display("%0t: pixel mismatch, expected %h, actual %h", $time, want, actual);
                n_errors++;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;  // [15:0] pixel_in, [23:16] ramp
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [15:0] pixel_out

    brighten_scoreboard sb = new();
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    int stall_cycles = 0;
    int layouts_used = 0;
    int pixels_sent  = 0;

    hicolor_pixel_brighten_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Result side: check on transfer, then pick the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= rx_gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tb_hicolor_pixel_brighten_unit failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [RAMP_W-1:0] ramp);
        if (tx_gaps_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ramp, pix};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_input(pix, ramp);
        pixels_sent++;
    endtask

    // Hold the input and wait for every outstanding pixel to come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // Write all six registers plus one to an unused index, which must be ignored.
    task automatic write_layout(input gun_cfg_arr_t lay);
        put_reg(CFG_RED_BITS,    lay[GUN_RED].bits);
        put_reg(CFG_RED_SHIFT,   lay[GUN_RED].shift);
        put_reg(CFG_GREEN_BITS,  lay[GUN_GREEN].bits);
        put_reg(CFG_GREEN_SHIFT, lay[GUN_GREEN].shift);
        put_reg(CFG_BLUE_BITS,   lay[GUN_BLUE].bits);
        put_reg(CFG_BLUE_SHIFT,  lay[GUN_BLUE].shift);
        put_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_W'($urandom));
        cfg_we <= 1'b0;
        layouts_used++;
    endtask

    function automatic gun_cfg_arr_t make_layout(int rb, int rs, int gb, int gs,
                                                 int bb, int bs);
        gun_cfg_arr_t lay;
        lay[GUN_RED].bits    = CFG_W'(rb);
        lay[GUN_RED].shift   = CFG_W'(rs);
        lay[GUN_GREEN].bits  = CFG_W'(gb);
        lay[GUN_GREEN].shift = CFG_W'(gs);
        lay[GUN_BLUE].bits   = CFG_W'(bb);
        lay[GUN_BLUE].shift  = CFG_W'(bs);
        return lay;
    endfunction

    // Mostly legal widths, but a fair share of zero and over-wide guns too.
    function automatic gun_cfg_arr_t random_layout();
        gun_cfg_arr_t lay;
        for (int g = 0; g < NUM_GUNS; g++) begin
            lay[g].bits  = ($urandom_range(99) < 25) ? CFG_W'($urandom_range(15))
                                                     : CFG_W'($urandom_range(GUN_MAX_W, 1));
            lay[g].shift = CFG_W'($urandom_range(15));
        end
        return lay;
    endfunction

    function automatic logic [RAMP_W-1:0] pick_ramp();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 8'd1;
            default: return RAMP_W'($urandom);
        endcase
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset layout, edge pixels and ramps
        send_pixel(16'h0000, 8'h00);
        send_pixel(16'hFFFF, 8'h00);
        send_pixel(16'hFFFF, 8'hFF);
        send_pixel(16'h0000, 8'hFF);
        send_pixel(16'hFFFF, 8'h01);
        send_pixel(16'h8000, 8'h80);
        send_pixel(16'h0001, 8'hFF);
        send_pixel(16'hF800, 8'hFF);
        send_pixel(16'h07E0, 8'h40);
        send_pixel(16'h001F, 8'h01);
        send_pixel(16'h5555, 8'hAA);
        send_pixel(16'hAAAA, 8'h55);
        drain_results();

        // Zero-width red, over-wide green, blue running past bit 15
        write_layout(make_layout(0, 11, 15, 3, 8, 12));
        send_pixel(16'hFFFF, 8'hFF);
        send_pixel(16'h1234, 8'h80);
        send_pixel(16'hF00F, 8'h01);
        send_pixel(16'h0FF0, 8'h00);
        send_pixel(16'h8421, 8'hC0);
        drain_results();

        // All three guns on the same bits: results OR together
        write_layout(make_layout(6, 4, 6, 4, 6, 4));
        send_pixel(16'h03F0, 8'hFF);
        send_pixel(16'h0150, 8'h7F);
        send_pixel(16'hFFFF, 8'h10);
        send_pixel(16'h0000, 8'h00);
        drain_results();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       write_layout(make_layout(RED_BITS_RST, RED_SHIFT_RST,
                                                  GREEN_BITS_RST, GREEN_SHIFT_RST,
                                                  BLUE_BITS_RST, BLUE_SHIFT_RST));
                1:       write_layout(make_layout(1, 0, 1, 0, 1, 0));
                2:       write_layout(make_layout(15, 15, 15, 15, 15, 15));
                3:       write_layout(make_layout(8, 0, 8, 8, 8, 15));
                default: write_layout(random_layout());
            endcase
            tx_gaps_on = (phase != 3);
            rx_gaps_on = (phase != 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2)
                    drain_results();
                send_pixel(PIX_W'($urandom), pick_ramp());
            end
            drain_results();
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;

        repeat (4) @(posedge aclk);
        $display("Sent %0d pixels and checked %0d under %0d gun layouts,", pixels_sent,
                 sb.n_checked, layouts_used);
        $display("with zero ramps, zero-width, over-wide, clipped and overlapping guns.");
        if (sb.n_errors == 0) begin
            $display("tb_hicolor_pixel_brighten_unit passed");
        end else begin
            $display("%0d mismatches", sb.n_errors);
            $display("tb_hicolor_pixel_brighten_unit failed");
        end
        $finish;
    end

endmodule
